>>> sv/cfe_pkg.sv
// shared types, constants and helper functions for the cuckoo filter engine
// no dependencies; used by cfe_row_match and cuckoo_filter_engine_unit

package cfe_pkg;

    // geometry
    localparam int BUCKET_BITS = 10;
    localparam int IDX_W       = BUCKET_BITS;
    localparam int SLOTS       = 4;
    localparam int SLOT_W      = 32;
    localparam int ROW_W       = SLOTS * SLOT_W;
    localparam int BUCKETS     = 1 << BUCKET_BITS;

    // field widths
    localparam int CMD_W   = 2;
    localparam int HASH_W  = 64;
    localparam int CODE_W  = 3;
    localparam int COUNT_W = 13;
    localparam int LFSR_W  = 16;
    localparam int KICK_W  = 10;
    localparam int TBITS_W = 6;
    localparam int IBITS_W = 4;

    // configuration port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [31:0]        ALT_MULT   = 32'h5bd1_e995;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 13'd8191;
    localparam logic [LFSR_W-1:0]  LFSR_TAPS  = 16'hB400;
    localparam logic [LFSR_W-1:0]  LFSR_SEED  = 16'h0001;

    localparam logic [TBITS_W-1:0] TAG_BITS_RST   = 6'd8;
    localparam logic [IBITS_W-1:0] INDEX_BITS_RST = 4'd10;
    localparam logic [KICK_W-1:0]  MAX_KICKS_RST  = 10'd500;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_TAG_BITS   = 2'd0;
    localparam logic [1:0] REG_INDEX_BITS = 2'd1;
    localparam logic [1:0] REG_MAX_KICKS  = 2'd2;

    // commands
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

    // result codes
    localparam logic [CODE_W-1:0] RES_MISS      = 3'd0;
    localparam logic [CODE_W-1:0] RES_HIT       = 3'd1;
    localparam logic [CODE_W-1:0] RES_INSERTED  = 3'd2;
    localparam logic [CODE_W-1:0] RES_PRESENT   = 3'd3;
    localparam logic [CODE_W-1:0] RES_FAILED    = 3'd4;
    localparam logic [CODE_W-1:0] RES_REFUSED   = 3'd5;
    localparam logic [CODE_W-1:0] RES_DELETED   = 3'd6;
    localparam logic [CODE_W-1:0] RES_NOT_FOUND = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [HASH_W-1:0] key_hash;
    } req_word_t;

    typedef struct packed {
        logic [CODE_W-1:0]  result_code;
        logic [COUNT_W-1:0] item_count;
        logic               full_flag;
    } rsp_word_t;

    // what the slot matcher reports about one bucket row
    typedef struct packed {
        logic       hit;
        logic [1:0] hit_slot;
        logic       empty;
        logic [1:0] empty_slot;
    } row_match_t;

    function automatic logic [SLOT_W-1:0] tag_mask_f(input logic [TBITS_W-1:0] tb);
        int          t;
        logic [32:0] m;
        t = int'(tb);
        if (t < 2) t = 2;
        if (t > 32) t = 32;
        m = (33'd1 << t) - 33'd1;
        return m[SLOT_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] idx_mask_f(input logic [IBITS_W-1:0] ib);
        int           t;
        logic [IDX_W:0] m;
        t = int'(ib);
        if (t < 1) t = 1;
        if (t > BUCKET_BITS) t = BUCKET_BITS;
        m = ({{IDX_W{1'b0}}, 1'b1} << t) - {{IDX_W{1'b0}}, 1'b1};
        return m[IDX_W-1:0];
    endfunction

    // only the low index bits of tag * ALT_MULT matter
    function automatic logic [IDX_W-1:0] alt_prod_f(input logic [SLOT_W-1:0] tag);
        logic [2*IDX_W-1:0] p;
        p = {{IDX_W{1'b0}}, tag[IDX_W-1:0]} * {{IDX_W{1'b0}}, ALT_MULT[IDX_W-1:0]};
        return p[IDX_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] get_slot(input logic [ROW_W-1:0] row,
                                                   input logic [1:0] j);
        return row[j*SLOT_W +: SLOT_W];
    endfunction

    function automatic logic [ROW_W-1:0] set_slot(input logic [ROW_W-1:0] row,
                                                  input logic [1:0] j,
                                                  input logic [SLOT_W-1:0] val);
        logic [ROW_W-1:0] r;
        r = row;
        r[j*SLOT_W +: SLOT_W] = val;
        return r;
    endfunction

endpackage

>>> sv/cfe_ram.sv
// generic single-write, single-read RAM with registered read data
// no dependencies

module cfe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/cfe_row_match.sv
// slot matcher: compares the four slots of one bucket row against a tag
// depends on cfe_pkg

module cfe_row_match (
    input  logic [cfe_pkg::ROW_W-1:0]  row,
    input  logic [cfe_pkg::SLOT_W-1:0] tag,
    input  logic [cfe_pkg::SLOT_W-1:0] mask,
    output cfe_pkg::row_match_t        result
);

    always_comb
    begin
        logic [cfe_pkg::SLOT_W-1:0] s;
        result = '0;
        // walk downward so the lowest matching slot wins
        for (int j = cfe_pkg::SLOTS - 1; j >= 0; j--)
        begin
            s = row[j*cfe_pkg::SLOT_W +: cfe_pkg::SLOT_W] & mask;
            if (s == tag)
            begin
                result.hit      = 1'b1;
                result.hit_slot = 2'(j);
            end
            if (s == '0)
            begin
                result.empty      = 1'b1;
                result.empty_slot = 2'(j);
            end
        end
    end

endmodule

>>> sv/cuckoo_filter_engine_unit.sv
// cuckoo filter engine top level: sequencer, config registers, bucket RAM
// depends on cfe_pkg, cfe_ram, cfe_row_match
//
//  channel   direction  handshake               word
//  req       in         req_valid / req_stall   cfe_pkg::req_word_t (command, key_hash)
//  rsp       out        rsp_valid / rsp_stall   cfe_pkg::rsp_word_t (code, count, full)
//  apb       in/out     psel / penable / pready tag_bits, index_bits, max_kicks
//
// after reset a clearing pass zeroes all 2^BUCKET_BITS (1024) rows of the bucket RAM, one row
// per cycle; req_stall stays high meanwhile, config writes are taken as usual.
// one request at a time, set by two bucket reads through the single read port: a request goes
// through mul, alt (first read), rd1 (second read), rd2 and fin; a delete that hits the first
// bucket skips from rd1 to fin; a probing insert adds kev, then kmul, kalt, kev per round of
// displacement. a result waiting under rsp_stall holds the sequencer in its last step only.

module cuckoo_filter_engine_unit (
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       req_valid,
    output logic                       req_stall,
    input  cfe_pkg::req_word_t         req_word,

    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output cfe_pkg::rsp_word_t         rsp_word,

    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cfe_pkg::APB_AW-1:0] paddr,
    input  logic [cfe_pkg::APB_DW-1:0] pwdata,
    output logic [cfe_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);

    typedef enum logic [10:0] {
        ST_CLEAR = 11'b000_0000_0001,
        ST_IDLE  = 11'b000_0000_0010,
        ST_MUL   = 11'b000_0000_0100,
        ST_ALT   = 11'b000_0000_1000,
        ST_RD1   = 11'b000_0001_0000,
        ST_RD2   = 11'b000_0010_0000,
        ST_KEV   = 11'b000_0100_0000,
        ST_KMUL  = 11'b000_1000_0000,
        ST_KALT  = 11'b001_0000_0000,
        ST_FIN   = 11'b010_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // config
    logic [cfe_pkg::TBITS_W-1:0] tag_bits_reg;
    logic [cfe_pkg::IBITS_W-1:0] index_bits_reg;
    logic [cfe_pkg::KICK_W-1:0]  max_kicks_reg;

    // control state
    logic [cfe_pkg::IDX_W-1:0]   clr_reg, clr_next;
    logic [cfe_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                        full_reg, full_next;
    logic [cfe_pkg::LFSR_W-1:0]  lfsr_reg, lfsr_next;
    logic                        rsp_valid_reg, rsp_valid_next;

    // working registers
    logic [cfe_pkg::CMD_W-1:0]   cmd_reg, cmd_next;
    logic [cfe_pkg::IDX_W-1:0]   i1_reg, i1_next;
    logic [cfe_pkg::IDX_W-1:0]   i2_reg, i2_next;
    logic [cfe_pkg::IDX_W-1:0]   cur_reg, cur_next;
    logic [cfe_pkg::IDX_W-1:0]   prod_reg, prod_next;
    logic [cfe_pkg::SLOT_W-1:0]  tag_reg, tag_next;
    logic [cfe_pkg::SLOT_W-1:0]  ctag_reg, ctag_next;
    logic                        hit1_reg, hit1_next;
    logic [cfe_pkg::CODE_W-1:0]  code_reg, code_next;
    logic [cfe_pkg::KICK_W-1:0]  round_reg, round_next;
    cfe_pkg::rsp_word_t          rsp_word_reg, rsp_word_next;

    // ram port
    logic                        ram_we;
    logic [cfe_pkg::IDX_W-1:0]   ram_waddr;
    logic [cfe_pkg::ROW_W-1:0]   ram_wdata;
    logic                        ram_re;
    logic [cfe_pkg::IDX_W-1:0]   ram_raddr;
    logic [cfe_pkg::ROW_W-1:0]   ram_rdata;

    logic [cfe_pkg::SLOT_W-1:0]  tmask;
    logic [cfe_pkg::IDX_W-1:0]   imask;
    logic [cfe_pkg::IDX_W-1:0]   alt_idx;
    logic [cfe_pkg::SLOT_W-1:0]  new_tag;
    logic [cfe_pkg::LFSR_W-1:0]  lfsr_step;
    logic                        last_round;
    logic                        apb_write;
    cfe_pkg::row_match_t         match;

    assign tmask   = cfe_pkg::tag_mask_f(tag_bits_reg);
    assign imask   = cfe_pkg::idx_mask_f(index_bits_reg);
    // shared alternate index unit: xor with the registered product
    assign alt_idx = (cur_reg ^ prod_reg) & imask;

    assign new_tag = ((req_word.key_hash[cfe_pkg::SLOT_W-1:0] & tmask) == '0)
                   ? {{(cfe_pkg::SLOT_W-1){1'b0}}, 1'b1}
                   : (req_word.key_hash[cfe_pkg::SLOT_W-1:0] & tmask);

    assign lfsr_step  = {1'b0, lfsr_reg[cfe_pkg::LFSR_W-1:1]}
                      ^ (lfsr_reg[0] ? cfe_pkg::LFSR_TAPS : '0);
    assign last_round = ({1'b0, round_reg} + 11'd1) == {1'b0, max_kicks_reg};

    cfe_ram #(
        .WIDTH (cfe_pkg::ROW_W),
        .DEPTH (cfe_pkg::BUCKETS)
    ) u_bucket_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cfe_row_match u_row_match (
        .row    (ram_rdata),
        .tag    (tag_reg),
        .mask   (tmask),
        .result (match)
    );

    // configuration port
    assign pready    = 1'b1;
    assign apb_write = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[3:2])
            cfe_pkg::REG_TAG_BITS:   prdata = {26'd0, tag_bits_reg};
            cfe_pkg::REG_INDEX_BITS: prdata = {28'd0, index_bits_reg};
            cfe_pkg::REG_MAX_KICKS:  prdata = {22'd0, max_kicks_reg};
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_bits_reg   <= cfe_pkg::TAG_BITS_RST;
            index_bits_reg <= cfe_pkg::INDEX_BITS_RST;
            max_kicks_reg  <= cfe_pkg::MAX_KICKS_RST;
        end
        else if (apb_write)
        begin
            case (paddr[3:2])
                cfe_pkg::REG_TAG_BITS:   tag_bits_reg   <= pwdata[cfe_pkg::TBITS_W-1:0];
                cfe_pkg::REG_INDEX_BITS: index_bits_reg <= pwdata[cfe_pkg::IBITS_W-1:0];
                cfe_pkg::REG_MAX_KICKS:  max_kicks_reg  <= pwdata[cfe_pkg::KICK_W-1:0];
                default:                 ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        count_next     = count_reg;
        full_next      = full_reg;
        lfsr_next      = lfsr_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_word_next  = rsp_word_reg;
        cmd_next       = cmd_reg;
        i1_next        = i1_reg;
        i2_next        = i2_reg;
        cur_next       = cur_reg;
        prod_next      = prod_reg;
        tag_next       = tag_reg;
        ctag_next      = ctag_reg;
        hit1_next      = hit1_reg;
        code_next      = code_reg;
        round_next     = round_reg;
        ram_we         = 1'b0;
        ram_waddr      = cur_reg;
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = cur_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next   = req_word.command;
                    i1_next    = req_word.key_hash[32 +: cfe_pkg::IDX_W] & imask;
                    cur_next   = req_word.key_hash[32 +: cfe_pkg::IDX_W] & imask;
                    tag_next   = new_tag;
                    ctag_next  = new_tag;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = cfe_pkg::alt_prod_f(ctag_reg);
                state_next = ST_ALT;
            end
            ST_ALT:
            begin
                i2_next    = alt_idx;
                ram_re     = 1'b1;
                ram_raddr  = i1_reg;
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                hit1_next = match.hit;
                if (cmd_reg == cfe_pkg::CMD_DELETE && match.hit)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = i1_reg;
                    ram_wdata  = cfe_pkg::set_slot(ram_rdata, match.hit_slot, '0);
                    count_next = (count_reg != '0) ? count_reg - 1'b1 : count_reg;
                    code_next  = cfe_pkg::RES_DELETED;
                    state_next = ST_FIN;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = i2_reg;
                    state_next = ST_RD2;
                end
            end
            ST_RD2:
            begin
                state_next = ST_FIN;
                case (cmd_reg)
                    cfe_pkg::CMD_INSERT:
                    begin
                        if (full_reg)
                        begin
                            code_next = cfe_pkg::RES_REFUSED;
                        end
                        else if (hit1_reg || match.hit)
                        begin
                            code_next = cfe_pkg::RES_PRESENT;
                        end
                        else if (max_kicks_reg == '0)
                        begin
                            full_next = 1'b1;
                            code_next = cfe_pkg::RES_FAILED;
                        end
                        else
                        begin
                            cur_next   = i1_reg;
                            round_next = '0;
                            ram_re     = 1'b1;
                            ram_raddr  = i1_reg;
                            state_next = ST_KEV;
                        end
                    end
                    cfe_pkg::CMD_DELETE:
                    begin
                        if (match.hit)
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = i2_reg;
                            ram_wdata  = cfe_pkg::set_slot(ram_rdata, match.hit_slot, '0);
                            count_next = (count_reg != '0) ? count_reg - 1'b1 : count_reg;
                            code_next  = cfe_pkg::RES_DELETED;
                        end
                        else
                        begin
                            code_next = cfe_pkg::RES_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        code_next = (hit1_reg || match.hit) ? cfe_pkg::RES_HIT
                                                            : cfe_pkg::RES_MISS;
                    end
                endcase
            end
            ST_KEV:
            begin
                if (match.empty)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = cfe_pkg::set_slot(ram_rdata, match.empty_slot, ctag_reg);
                    count_next = (count_reg != cfe_pkg::COUNT_MAX) ? count_reg + 1'b1
                                                                   : count_reg;
                    code_next  = cfe_pkg::RES_INSERTED;
                    state_next = ST_FIN;
                end
                else
                begin
                    // first round only probes; later rounds displace a victim
                    if (round_reg != '0)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = cfe_pkg::set_slot(ram_rdata, lfsr_reg[1:0], ctag_reg);
                        ctag_next = cfe_pkg::get_slot(ram_rdata, lfsr_reg[1:0]) & tmask;
                        lfsr_next = lfsr_step;
                    end
                    if (last_round)
                    begin
                        full_next  = 1'b1;
                        code_next  = cfe_pkg::RES_FAILED;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        round_next = round_reg + 1'b1;
                        state_next = ST_KMUL;
                    end
                end
            end
            ST_KMUL:
            begin
                prod_next  = cfe_pkg::alt_prod_f(ctag_reg);
                state_next = ST_KALT;
            end
            ST_KALT:
            begin
                cur_next   = alt_idx;
                ram_re     = 1'b1;
                ram_raddr  = alt_idx;
                state_next = ST_KEV;
            end
            ST_FIN:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_word_next.result_code = code_reg;
                    rsp_word_next.item_count  = count_reg;
                    rsp_word_next.full_flag   = full_reg;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            full_reg      <= 1'b0;
            lfsr_reg      <= cfe_pkg::LFSR_SEED;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            full_reg      <= full_next;
            lfsr_reg      <= lfsr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        i1_reg       <= i1_next;
        i2_reg       <= i2_next;
        cur_reg      <= cur_next;
        prod_reg     <= prod_next;
        tag_reg      <= tag_next;
        ctag_reg     <= ctag_next;
        hit1_reg     <= hit1_next;
        code_reg     <= code_next;
        round_reg    <= round_next;
        rsp_word_reg <= rsp_word_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

`ifndef NO_ASSERTIONS
    // the full flag is sticky until reset
    a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(full_reg))
        else $error("full flag cleared outside reset");

    // a zero lfsr would lock the victim choice
    a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_reg != '0)
        else $error("victim lfsr reached zero");

    // a new result word only comes out of the final step
    a_rsp_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result raised outside the final step");

    // bucket writes only during clearing or a modifying step
    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_RD1 ||
                    state_reg == ST_RD2 || state_reg == ST_KEV))
        else $error("bucket write in a non-writing step");

    // lookups never change the stored count
    a_lookup_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD2 && cmd_reg != cfe_pkg::CMD_INSERT &&
         cmd_reg != cfe_pkg::CMD_DELETE) |=> $stable(count_reg))
        else $error("lookup changed the item count");
`endif

endmodule
